// File: rtl/awm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awm_pkg
// Shared constants, register codes and types for the anagram window matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

  localparam int MAX_WINDOW_DEF    = 63;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int POSITION_BITS_DEF = 16;

  localparam int LETTER_W    = 5;
  localparam int COUNT_W     = 6;
  localparam int WLEN_W      = 6;
  localparam int CFG_DATA_W  = 60;
  localparam int CFG_IDX_W   = 2;
  localparam int INDEX_W     = 16;
  localparam int NUM_LETTERS = 26;
  localparam int PAT_AJ_W    = 60;
  localparam int PAT_KT_W    = 60;
  localparam int PAT_UZ_W    = 36;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 2'd0,
    CFG_PATTERN_A_J   = 2'd1,
    CFG_PATTERN_K_T   = 2'd2,
    CFG_PATTERN_U_Z   = 2'd3
  } cfg_index_e;

  // stage register contents handed from the front end to the count lanes
  typedef struct packed {
    logic                letter_ok;
    logic [LETTER_W-1:0] letter;
    logic                start;
    logic                remove;
    logic                full;
    logic [INDEX_W-1:0]  start_index;
    logic                overflow;
  } awm_stage_t;

  function automatic logic [COUNT_W-1:0] pattern_count(
    input logic [PAT_AJ_W-1:0] a_j,
    input logic [PAT_KT_W-1:0] k_t,
    input logic [PAT_UZ_W-1:0] u_z,
    input int unsigned         idx
  );
    logic [COUNT_W-1:0] res;
    res = '0;
    if (idx < 10) begin
      res = a_j[COUNT_W*idx +: COUNT_W];
    end else if (idx < 20) begin
      res = k_t[COUNT_W*(idx-10) +: COUNT_W];
    end else if (idx < NUM_LETTERS) begin
      res = u_z[COUNT_W*(idx-20) +: COUNT_W];
    end
    return res;
  endfunction

endpackage

// File: rtl/anagram_window_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_window_matcher
// Sliding-window anagram search over a stream of letter indices.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one letter word (letter_i,
// start_new_i); a word moves when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word (match_o, start_index_o, position_overflow_o), in order.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i;
// write only while the block is idle.
// Path: a taken letter is registered in the input stage, then its result
// word in the result register, which offers it until it is taken.
// Throughput: one letter per cycle unless the output stalls. Count lanes
// update in the second stage; the ring RAM has one write and one registered
// read port: a read per letter, a write per letter inside the alphabet.
// Stall: with the result register held, one more letter is still taken into
// the input stage; after that in_stall_o follows out_stall_i.
// Reset: counts, position, overflow and the ring pointer clear; window
// length is one and pattern counts zero. The ring holds stale data, which
// is never read before it is written in normal use.
// ----------------------------------------------------------------------------
module anagram_window_matcher #(
  parameter int MAX_WINDOW    = awm_pkg::MAX_WINDOW_DEF,
  parameter int ALPHABET_SIZE = awm_pkg::ALPHABET_SIZE_DEF,
  parameter int POSITION_BITS = awm_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [awm_pkg::LETTER_W-1:0]    letter_i,
  input  logic                            start_new_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            match_o,
  output logic [awm_pkg::INDEX_W-1:0]     start_index_o,
  output logic                            position_overflow_o,
  input  logic                            cfg_we_i,
  input  logic [awm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [awm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [awm_pkg::WLEN_W-1:0]    wlen_q;
  logic [awm_pkg::PAT_AJ_W-1:0]  pat_a_j_q;
  logic [awm_pkg::PAT_KT_W-1:0]  pat_k_t_q;
  logic [awm_pkg::PAT_UZ_W-1:0]  pat_u_z_q;

  logic                          s1_valid_q, s1_valid_d;
  logic                          out_valid_q, out_valid_d;
  logic                          match_q;
  logic [awm_pkg::INDEX_W-1:0]   start_index_q;
  logic                          ovf_out_q;

  logic                          out_adv, s1_adv, accept, match_w;
  awm_pkg::awm_stage_t           stage;
  logic [awm_pkg::LETTER_W-1:0]  old_letter;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= awm_pkg::WLEN_W'(1);
      pat_a_j_q <= '0;
      pat_k_t_q <= '0;
      pat_u_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (awm_pkg::cfg_index_e'(cfg_index_i))
        awm_pkg::CFG_WINDOW_LENGTH: wlen_q    <= cfg_data_i[awm_pkg::WLEN_W-1:0];
        awm_pkg::CFG_PATTERN_A_J:   pat_a_j_q <= cfg_data_i[awm_pkg::PAT_AJ_W-1:0];
        awm_pkg::CFG_PATTERN_K_T:   pat_k_t_q <= cfg_data_i[awm_pkg::PAT_KT_W-1:0];
        awm_pkg::CFG_PATTERN_U_Z:   pat_u_z_q <= cfg_data_i[awm_pkg::PAT_UZ_W-1:0];
        default:                    wlen_q    <= wlen_q;
      endcase
    end
  end

  // pipeline flow control
  assign out_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_adv;
  assign in_stall_o  = s1_valid_q && !out_adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = accept || (s1_valid_q && !out_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  awm_front #(
    .MAX_WINDOW    (MAX_WINDOW),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .letter_i        (letter_i),
    .start_new_i     (start_new_i),
    .window_length_i (wlen_q),
    .stage_o         (stage),
    .old_letter_o    (old_letter)
  );

  awm_counts #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_counts (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (s1_adv),
    .stage_i      (stage),
    .old_letter_i (old_letter),
    .pat_a_j_i    (pat_a_j_q),
    .pat_k_t_i    (pat_k_t_q),
    .pat_u_z_i    (pat_u_z_q),
    .match_o      (match_w)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      match_q       <= match_w;
      start_index_q <= match_w ? stage.start_index : '0;
      ovf_out_q     <= stage.overflow;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign match_o             = match_q;
  assign start_index_o       = start_index_q;
  assign position_overflow_o = ovf_out_q;

  a_idx_zero_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_o |-> start_index_o == '0)
    else $error("start index set without a match");

  a_bad_letter_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !stage.letter_ok |=> out_valid_o && !match_o)
    else $error("match reported for a letter outside the alphabet");

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && s1_valid_q)
    else $error("input stalled while the pipeline could move");

endmodule

// File: rtl/awm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module awm_ram #(
  parameter int WIDTH  = 5,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/awm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awm_front
// Input stage: text position, overflow, letter ring and window flags.
// ----------------------------------------------------------------------------
module awm_front #(
  parameter int MAX_WINDOW    = awm_pkg::MAX_WINDOW_DEF,
  parameter int ALPHABET_SIZE = awm_pkg::ALPHABET_SIZE_DEF,
  parameter int POSITION_BITS = awm_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [awm_pkg::LETTER_W-1:0]  letter_i,
  input  logic                          start_new_i,
  input  logic [awm_pkg::WLEN_W-1:0]    window_length_i,
  output awm_pkg::awm_stage_t           stage_o,
  output logic [awm_pkg::LETTER_W-1:0]  old_letter_o
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int AW    = PW + 2;
  localparam int PB1   = POSITION_BITS + 1;
  localparam int IW    = (PB1 > awm_pkg::INDEX_W) ? PB1 : awm_pkg::INDEX_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [PW-1:0]                 ptr_q, ptr_d;
  logic [POSITION_BITS-1:0]      pos_q, pos_d;
  logic                          ovf_q, ovf_d;
  awm_pkg::awm_stage_t           stage_q, stage_d;

  logic [awm_pkg::WLEN_W-1:0]    k_w;
  logic                          letter_ok;
  logic [AW-1:0]                 back_sum;
  logic [POSITION_BITS-1:0]      pos_base;
  logic                          ovf_base;
  logic [PB1-1:0]                pos_p1;
  logic [IW-1:0]                 sidx_w;
  logic                          pos_sat;

  // effective window: zero acts as one, clamp to MAX_WINDOW (one less than the ring size)
  always_comb begin
    k_w = window_length_i;
    if (k_w == '0) begin
      k_w = awm_pkg::WLEN_W'(1);
    end
    if (32'(k_w) > MAX_WINDOW) begin
      k_w = awm_pkg::WLEN_W'(MAX_WINDOW);
    end
  end

  assign letter_ok = (32'(letter_i) < ALPHABET_SIZE) && (32'(letter_i) < awm_pkg::NUM_LETTERS);

  // ring slot of the letter leaving the window
  always_comb begin
    back_sum = AW'(ptr_q) + AW'(DEPTH) - AW'(k_w);
    if (back_sum >= AW'(DEPTH)) begin
      back_sum = back_sum - AW'(DEPTH);
    end
  end

  always_comb begin
    pos_base = start_new_i ? '0 : pos_q;
    ovf_base = start_new_i ? 1'b0 : ovf_q;
    pos_sat  = (pos_base == POS_MAX);
    pos_p1   = {1'b0, pos_base} + PB1'(1);
    sidx_w   = IW'(pos_base) + IW'(1) - IW'(k_w);

    pos_d = pos_base;
    ovf_d = ovf_base;
    ptr_d = ptr_q;
    if (letter_ok) begin
      pos_d = pos_sat ? pos_base : pos_p1[POSITION_BITS-1:0];
      ovf_d = ovf_base | pos_sat;
      ptr_d = (ptr_q == PW'(DEPTH - 1)) ? '0 : ptr_q + PW'(1);
    end

    stage_d.letter_ok   = letter_ok;
    stage_d.letter      = letter_i;
    stage_d.start       = start_new_i;
    stage_d.remove      = letter_ok && ({1'b0, pos_base} >= PB1'(k_w));
    stage_d.full        = letter_ok && (pos_p1 >= PB1'(k_w));
    stage_d.start_index = sidx_w[awm_pkg::INDEX_W-1:0];
    stage_d.overflow    = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept_i) begin
      ptr_q <= ptr_d;
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  awm_ram #(
    .WIDTH (awm_pkg::LETTER_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept_i && letter_ok),
    .waddr_i (ptr_q),
    .wdata_i (letter_i),
    .re_i    (accept_i),
    .raddr_i (back_sum[PW-1:0]),
    .rdata_o (old_letter_o)
  );

  assign stage_o = stage_q;

endmodule

// File: rtl/awm_counts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awm_counts
// Per-letter count lanes with saturating update and pattern compare.
// ----------------------------------------------------------------------------
module awm_counts #(
  parameter int ALPHABET_SIZE = awm_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  awm_pkg::awm_stage_t           stage_i,
  input  logic [awm_pkg::LETTER_W-1:0]  old_letter_i,
  input  logic [awm_pkg::PAT_AJ_W-1:0]  pat_a_j_i,
  input  logic [awm_pkg::PAT_KT_W-1:0]  pat_k_t_i,
  input  logic [awm_pkg::PAT_UZ_W-1:0]  pat_u_z_i,
  output logic                          match_o
);

  logic [ALPHABET_SIZE-1:0] eq;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_lane
    logic [awm_pkg::COUNT_W-1:0] cnt_q, cnt_d, cnt_inc;
    logic                        inc, dec;

    assign inc = stage_i.letter_ok && (32'(stage_i.letter) == 32'(i));
    assign dec = stage_i.remove && (32'(old_letter_i) == 32'(i));

    // add first, then remove; both clamp
    always_comb begin
      cnt_d = stage_i.start ? '0 : cnt_q;
      cnt_inc = (inc && (cnt_d != awm_pkg::COUNT_MAX)) ? cnt_d + 1'b1 : cnt_d;
      cnt_d = (dec && (cnt_inc != '0)) ? cnt_inc - 1'b1 : cnt_inc;
    end

    assign eq[i] = (cnt_d == awm_pkg::pattern_count(pat_a_j_i, pat_k_t_i, pat_u_z_i, i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q <= '0;
      end else if (advance_i) begin
        cnt_q <= cnt_d;
      end
    end
  end

  assign match_o = stage_i.full && (&eq);

endmodule

// File: tb/anagram_window_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_window_matcher_test
// Self-checking bench for the sliding-window anagram matcher. A short table
// of hand-picked letters comes first, then phases of random texts built
// around anagrams of a random pattern word, under several idle and stall
// mixes, one of them a dense text over two letters in a window of two.
// Results are checked against typed entries or a window-count predictor.
// ----------------------------------------------------------------------------
module anagram_window_matcher_test;

  localparam int RING_SLOTS = awm_pkg::MAX_WINDOW_DEF + 1;
  localparam int LIMIT_NS = 4_000_000;
  localparam int NUM_PHASES = 12;
  localparam int HOLD_PHASE = 4;
  localparam int PAIR_PHASE = 10;
  localparam int WORDS_PER_PHASE = 60;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PROBES = 18;

  localparam logic [awm_pkg::POSITION_BITS_DEF-1:0] POS_TOP = '1;

  localparam logic [awm_pkg::LETTER_W-1:0] L_A = 5'd0;
  localparam logic [awm_pkg::LETTER_W-1:0] L_B = 5'd1;
  localparam logic [awm_pkg::LETTER_W-1:0] L_C = 5'd2;
  localparam logic [awm_pkg::LETTER_W-1:0] L_P = 5'd15;
  localparam logic [awm_pkg::LETTER_W-1:0] L_Q = 5'd16;
  localparam logic [awm_pkg::LETTER_W-1:0] L_Z = 5'd25;
  localparam logic [awm_pkg::LETTER_W-1:0] L_BAD_LO = 5'd26;
  localparam logic [awm_pkg::LETTER_W-1:0] L_BAD_HI = 5'd31;

  localparam logic TYPED = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic                         hit;
    logic [awm_pkg::INDEX_W-1:0]  first_idx;
    logic                         sat;
  } match_res_t;

  typedef struct packed {
    logic [awm_pkg::LETTER_W-1:0] ltr;
    logic                         fresh;
    logic                         known;
    logic                         hit;
    logic [awm_pkg::INDEX_W-1:0]  first_idx;
    logic                         sat;
  } probe_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [awm_pkg::LETTER_W-1:0]   letter;
  logic                           start_new;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           match;
  logic [awm_pkg::INDEX_W-1:0]    start_index;
  logic                           pos_overflow;
  logic                           cfg_we;
  awm_pkg::cfg_index_e            cfg_index;
  logic [awm_pkg::CFG_DATA_W-1:0] cfg_data;

  // local copy of the configuration and the window state
  logic [awm_pkg::WLEN_W-1:0]     win_len = 6'd1;
  logic [awm_pkg::PAT_AJ_W-1:0]   pat_aj = '0;
  logic [awm_pkg::PAT_KT_W-1:0]   pat_kt = '0;
  logic [awm_pkg::PAT_UZ_W-1:0]   pat_uz = '0;
  logic [awm_pkg::COUNT_W-1:0]    win_count [awm_pkg::NUM_LETTERS] = '{default: '0};
  logic [awm_pkg::LETTER_W-1:0]   recent [RING_SLOTS] = '{default: '0};
  int unsigned                    recent_wr = 0;
  logic [awm_pkg::POSITION_BITS_DEF-1:0] text_pos = '0;
  logic                           pos_sat = 1'b0;

  match_res_t            pending_matches [$];
  int                    fail_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_req = 0;
  int                    hold_taken = 0;
  int                    hold_left = 0;

  // pattern word "abc" in a window of three
  probe_t probes [NUM_PROBES] = '{
    '{L_C,      1'b1, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_B,      1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_A,      1'b0, TYPED,     1'b1, 16'd0, 1'b0},
    '{L_C,      1'b0, TYPED,     1'b1, 16'd1, 1'b0},
    '{L_BAD_HI, 1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_BAD_LO, 1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_B,      1'b0, TYPED,     1'b1, 16'd2, 1'b0},
    '{L_Z,      1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_A,      1'b1, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_BAD_HI, 1'b1, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_A,      1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_B,      1'b0, TYPED,     1'b0, 16'd0, 1'b0},
    '{L_C,      1'b0, TYPED,     1'b1, 16'd0, 1'b0},
    '{L_Q,      1'b0, PREDICTED, 1'b0, 16'd0, 1'b0},
    '{L_C,      1'b0, PREDICTED, 1'b0, 16'd0, 1'b0},
    '{L_P,      1'b0, PREDICTED, 1'b0, 16'd0, 1'b0},
    '{L_A,      1'b0, PREDICTED, 1'b0, 16'd0, 1'b0},
    '{L_B,      1'b0, PREDICTED, 1'b0, 16'd0, 1'b0}
  };

  anagram_window_matcher u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .letter_i            (letter),
    .start_new_i         (start_new),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .match_o             (match),
    .start_index_o       (start_index),
    .position_overflow_o (pos_overflow),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [awm_pkg::COUNT_W-1:0] pattern_of(input int unsigned ltr);
    logic [awm_pkg::COUNT_W*awm_pkg::NUM_LETTERS-1:0] all_counts;
    all_counts = {pat_uz, pat_kt, pat_aj};
    return all_counts[awm_pkg::COUNT_W*ltr +: awm_pkg::COUNT_W];
  endfunction

  // add the new letter, drop the one leaving the window, then compare
  function automatic match_res_t advance_window(input logic [awm_pkg::LETTER_W-1:0] ltr,
                                                input logic fresh);
    match_res_t                   r;
    int unsigned                  k;
    int unsigned                  pos;
    int unsigned                  back;
    logic [awm_pkg::LETTER_W-1:0] gone;
    r = '0;
    k = (win_len == 0) ? 1 : int'(win_len);
    if (fresh) begin
      foreach (win_count[i]) win_count[i] = '0;
      text_pos = '0;
      pos_sat = 1'b0;
    end
    if (ltr < awm_pkg::NUM_LETTERS) begin
      pos = text_pos;
      if (win_count[ltr] != awm_pkg::COUNT_MAX) win_count[ltr] = win_count[ltr] + 1'b1;
      if (pos >= k) begin
        back = (recent_wr + RING_SLOTS - k) % RING_SLOTS;
        gone = recent[back];
        if (win_count[gone] != '0) win_count[gone] = win_count[gone] - 1'b1;
      end
      recent[recent_wr] = ltr;
      recent_wr = (recent_wr + 1) % RING_SLOTS;
      if (text_pos == POS_TOP) pos_sat = 1'b1;
      else text_pos = text_pos + 1'b1;
      if (pos + 1 >= k) begin
        r.hit = 1'b1;
        for (int i = 0; i < awm_pkg::NUM_LETTERS; i++) begin
          if (win_count[i] != pattern_of(i)) r.hit = 1'b0;
        end
        if (r.hit) r.first_idx = awm_pkg::INDEX_W'(pos + 1 - k);
      end
    end
    r.sat = pos_sat;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input awm_pkg::cfg_index_e sel,
                           input logic [awm_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (sel)
      awm_pkg::CFG_WINDOW_LENGTH: win_len = data[awm_pkg::WLEN_W-1:0];
      awm_pkg::CFG_PATTERN_A_J:   pat_aj = data[awm_pkg::PAT_AJ_W-1:0];
      awm_pkg::CFG_PATTERN_K_T:   pat_kt = data[awm_pkg::PAT_KT_W-1:0];
      awm_pkg::CFG_PATTERN_U_Z:   pat_uz = data[awm_pkg::PAT_UZ_W-1:0];
      default: ;
    endcase
  endtask

  // offer one letter word; the expectation is queued when it is taken
  task automatic send_word(input logic [awm_pkg::LETTER_W-1:0] ltr, input logic fresh,
                           input logic known, input match_res_t typed);
    match_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    letter = ltr;
    start_new = fresh;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = advance_window(ltr, fresh);
    pending_matches = {pending_matches, (known ? typed : r)};
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    match_res_t want;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_matches.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result word with nothing expected: match %b index %0d ovf %b",
                   $realtime, match, start_index, pos_overflow);
      end else begin
        want = pending_matches.pop_front();
        if (match !== want.hit || start_index !== want.first_idx ||
            pos_overflow !== want.sat) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: exp match %b index %0d ovf %b, got match %b index %0d ovf %b",
                     $realtime, want.hit, want.first_idx, want.sat,
                     match, start_index, pos_overflow);
        end
      end
    end
  end

  initial begin
    logic [awm_pkg::LETTER_W-1:0]   word [awm_pkg::MAX_WINDOW_DEF];
    logic [awm_pkg::LETTER_W-1:0]   perm [awm_pkg::MAX_WINDOW_DEF];
    logic [awm_pkg::LETTER_W-1:0]   alpha [4];
    logic [awm_pkg::LETTER_W-1:0]   tmp;
    logic [awm_pkg::LETTER_W-1:0]   ltr;
    logic [awm_pkg::WLEN_W-1:0]     k_raw;
    logic [awm_pkg::COUNT_W*awm_pkg::NUM_LETTERS-1:0] counts;
    logic [awm_pkg::CFG_DATA_W-1:0] junk;
    logic                           first;
    int                             keff;
    int                             sub_n;
    int                             sent;
    int                             roll;
    int                             j;

    rst_n = 1'b0;
    in_valid = 1'b0;
    letter = '0;
    start_new = 1'b0;
    cfg_we = 1'b0;
    cfg_index = awm_pkg::CFG_WINDOW_LENGTH;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(awm_pkg::CFG_WINDOW_LENGTH, 60'd3);
    write_reg(awm_pkg::CFG_PATTERN_A_J, 60'h1041);  // one each of a, b, c
    write_reg(awm_pkg::CFG_PATTERN_K_T, '0);
    write_reg(awm_pkg::CFG_PATTERN_U_Z, '0);
    foreach (probes[i])
      send_word(probes[i].ltr, probes[i].fresh, probes[i].known,
                '{probes[i].hit, probes[i].first_idx, probes[i].sat});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // sender waits here until every result word is back
      in_valid = 1'b0;
      while (pending_matches.size() != 0) @(posedge clk);
      @(negedge clk);

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == HOLD_PHASE || ph == PAIR_PHASE) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      case (ph)
        0:          k_raw = 6'd1;
        1, 3:       k_raw = 6'd63;
        2:          k_raw = 6'd0;   // acts as a window of one
        PAIR_PHASE: k_raw = 6'd2;
        default:    k_raw = ($urandom_range(6) == 0)
                            ? awm_pkg::WLEN_W'($urandom_range(63, 13))
                            : awm_pkg::WLEN_W'($urandom_range(12, 1));
      endcase
      keff = (k_raw == 0) ? 1 : int'(k_raw);

      sub_n = $urandom_range(4, 1);
      foreach (alpha[i])
        alpha[i] = awm_pkg::LETTER_W'($urandom_range(awm_pkg::NUM_LETTERS - 1));
      if (ph == 3) begin
        // 63 of one letter: the count saturates before the oldest one leaves
        sub_n = 1;
        alpha[0] = L_A;
      end else if (ph == PAIR_PHASE) begin
        sub_n = 2;
        alpha[0] = L_A;
        alpha[1] = L_B;
      end
      counts = '0;
      for (int i = 0; i < keff; i++) begin
        word[i] = alpha[$urandom_range(sub_n - 1)];
        counts[awm_pkg::COUNT_W*word[i] +: awm_pkg::COUNT_W] =
          counts[awm_pkg::COUNT_W*word[i] +: awm_pkg::COUNT_W] + 1'b1;
      end

      junk = awm_pkg::CFG_DATA_W'({$urandom, $urandom});
      write_reg(awm_pkg::CFG_WINDOW_LENGTH,
                (ph % 2) ? {junk[awm_pkg::CFG_DATA_W-1:awm_pkg::WLEN_W], k_raw}
                         : awm_pkg::CFG_DATA_W'(k_raw));
      if (ph == 6) begin
        write_reg(awm_pkg::CFG_PATTERN_A_J, '1);
        write_reg(awm_pkg::CFG_PATTERN_K_T, '1);
        write_reg(awm_pkg::CFG_PATTERN_U_Z, '1);
      end else if (ph == 7) begin
        write_reg(awm_pkg::CFG_PATTERN_A_J, awm_pkg::CFG_DATA_W'({$urandom, $urandom}));
        write_reg(awm_pkg::CFG_PATTERN_K_T, awm_pkg::CFG_DATA_W'({$urandom, $urandom}));
        write_reg(awm_pkg::CFG_PATTERN_U_Z, awm_pkg::CFG_DATA_W'({$urandom, $urandom}));
      end else begin
        write_reg(awm_pkg::CFG_PATTERN_A_J, counts[0 +: awm_pkg::PAT_AJ_W]);
        write_reg(awm_pkg::CFG_PATTERN_K_T,
                  counts[awm_pkg::PAT_AJ_W +: awm_pkg::PAT_KT_W]);
        write_reg(awm_pkg::CFG_PATTERN_U_Z, (ph % 2) ?
                  {junk[awm_pkg::CFG_DATA_W-1:awm_pkg::PAT_UZ_W],
                   counts[awm_pkg::PAT_AJ_W+awm_pkg::PAT_KT_W +: awm_pkg::PAT_UZ_W]} :
                  awm_pkg::CFG_DATA_W'(
                    counts[awm_pkg::PAT_AJ_W+awm_pkg::PAT_KT_W +: awm_pkg::PAT_UZ_W]));
      end

      // some phases carry on the previous text under the new window length
      first = (ph == 0 || ph == PAIR_PHASE || ph == NUM_PHASES - 1) ? 1'b1
                                                                    : ($urandom_range(9) < 6);
      if (ph == HOLD_PHASE) hold_req = hold_req + 1;

      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          for (int i = 0; i < keff; i++) perm[i] = word[i];
          for (j = keff - 1; j > 0; j--) begin
            roll = $urandom_range(j);
            tmp = perm[j];
            perm[j] = perm[roll];
            perm[roll] = tmp;
          end
          for (int i = 0; i < keff; i++) begin
            send_word(perm[i], first, PREDICTED, '0);
            first = 1'b0;
          end
          sent = sent + keff;
        end else begin
          if (roll < 75) ltr = alpha[$urandom_range(sub_n - 1)];
          else if (roll < 83)
            ltr = awm_pkg::LETTER_W'($urandom_range(31, awm_pkg::NUM_LETTERS));
          else if (roll < 92)
            ltr = awm_pkg::LETTER_W'($urandom_range(awm_pkg::NUM_LETTERS - 1));
          else begin
            ltr = awm_pkg::LETTER_W'($urandom_range(31));
            first = 1'b1;
          end
          send_word(ltr, first, PREDICTED, '0);
          first = 1'b0;
          if (ltr < awm_pkg::NUM_LETTERS) sent = sent + 1;
        end
      end
    end

    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
